[hdl/bfhp_pkg.sv]
// ----------------------------------------------------------------------------
// bfhp_pkg - bit-file header parser package
// Item types, parser state, phase and error codes, and the magic header table.
// ----------------------------------------------------------------------------
`default_nettype none

package bfhp_pkg;

  // Input item: one raw file byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result item: one per input byte
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic        file_done;
    logic [1:0]  status;
    logic [31:0] payload_length;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_SEC_ID  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_TEXT    = 3'd4,
    PH_MARKER  = 3'd5,
    PH_PLEN    = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_MARKER = 2'd2,
    ERR_LENGTH = 2'd3
  } err_e;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_e      phase;
    logic [3:0]  field_cnt;   // byte count inside magic or length field
    logic [2:0]  sec_idx;     // info sections finished
    logic [15:0] sec_rem;     // text bytes left in current section
    logic [31:0] decl_len;
    logic [31:0] pay_rem;
    err_e        err;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:     PH_MAGIC,
    field_cnt: 4'd0,
    sec_idx:   3'd0,
    sec_rem:   16'd0,
    decl_len:  32'd0,
    pay_rem:   32'd0,
    err:       ERR_NONE
  };

  localparam logic [3:0] MagicLen   = 4'd13;
  localparam logic [3:0] PlenBytes  = 4'd4;
  localparam logic [7:0] MarkerByte = 8'h65;  // 'e'

  // Expected byte at each magic header position
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h09;
      4'd2:    b = 8'h0f;
      4'd3:    b = 8'hf0;
      4'd4:    b = 8'h0f;
      4'd5:    b = 8'hf0;
      4'd6:    b = 8'h0f;
      4'd7:    b = 8'hf0;
      4'd8:    b = 8'h0f;
      4'd9:    b = 8'hf0;
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h00;
      4'd12:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/bfhp_stream_if.sv]
// ----------------------------------------------------------------------------
// bfhp_stream_if - valid/ready stream channel
// Carries valid, ready and a payload of the type given at instantiation.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfhp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/bfhp_step.sv]
// ----------------------------------------------------------------------------
// bfhp_step - per-byte parser logic
// Computes the next parser state and the result item for one file byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bfhp_step #(
  parameter int INFO_SECTIONS = 4
) (
  input  bfhp_pkg::parse_state_t state_i,
  input  bfhp_pkg::in_item_t     item_i,
  output bfhp_pkg::parse_state_t state_o,
  output bfhp_pkg::out_item_t    result_o
);
  import bfhp_pkg::*;

  localparam logic [2:0] SecCount = 3'(INFO_SECTIONS);

  parse_state_t nxt;
  logic [7:0]   flipped;
  logic [2:0]   sec_inc;
  logic [15:0]  len_full;
  logic [15:0]  rem_dec;
  logic [31:0]  len_shift;
  phase_e       sec_end_phase;

  // Mirror the byte: bit i moves to bit 7-i
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      flipped[i] = item_i.data_byte[7-i];
    end
  end

  assign sec_inc       = state_i.sec_idx + 3'd1;
  assign sec_end_phase = (sec_inc >= SecCount) ? PH_MARKER : PH_SEC_ID;
  assign len_full      = {state_i.sec_rem[15:8], item_i.data_byte};
  assign rem_dec       = state_i.sec_rem - 16'd1;
  assign len_shift     = {state_i.decl_len[23:0], item_i.data_byte};

  // Advance the header walk
  always_comb begin
    nxt                    = state_i;
    result_o.out_byte      = 8'h00;
    result_o.payload_valid = 1'b0;
    if (state_i.err == ERR_NONE) begin
      case (state_i.phase)
        PH_MAGIC: begin
          if (state_i.field_cnt >= MagicLen ||
              item_i.data_byte != magic_byte(state_i.field_cnt)) begin
            nxt.err = ERR_MAGIC;
          end else if (state_i.field_cnt == MagicLen - 4'd1) begin
            nxt.field_cnt = 4'd0;
            nxt.phase     = PH_SEC_ID;
          end else begin
            nxt.field_cnt = state_i.field_cnt + 4'd1;
          end
        end
        PH_SEC_ID: begin
          nxt.phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          nxt.sec_rem = {item_i.data_byte, 8'h00};
          nxt.phase   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          nxt.sec_rem = len_full;
          if (len_full == 16'd0) begin
            nxt.sec_idx = sec_inc;
            nxt.phase   = sec_end_phase;
          end else begin
            nxt.phase = PH_TEXT;
          end
        end
        PH_TEXT: begin
          nxt.sec_rem = rem_dec;
          if (rem_dec == 16'd0) begin
            nxt.sec_idx = sec_inc;
            nxt.phase   = sec_end_phase;
          end
        end
        PH_MARKER: begin
          if (item_i.data_byte != MarkerByte) begin
            nxt.err = ERR_MARKER;
          end else begin
            nxt.field_cnt = 4'd0;
            nxt.phase     = PH_PLEN;
          end
        end
        PH_PLEN: begin
          nxt.decl_len = len_shift;
          if (state_i.field_cnt == PlenBytes - 4'd1) begin
            nxt.field_cnt = 4'd0;
            nxt.pay_rem   = len_shift;
            nxt.phase     = PH_PAYLOAD;
          end else begin
            nxt.field_cnt = state_i.field_cnt + 4'd1;
          end
        end
        PH_PAYLOAD: begin
          if (state_i.pay_rem == 32'd0) begin
            nxt.err = ERR_LENGTH;
          end else begin
            result_o.out_byte      = flipped;
            result_o.payload_valid = 1'b1;
            nxt.pay_rem            = state_i.pay_rem - 32'd1;
          end
        end
        default: begin
          nxt = state_i;
        end
      endcase
    end

    // Flag a file that ends anywhere but exactly after its payload
    if (item_i.last_byte && nxt.err == ERR_NONE &&
        (nxt.phase != PH_PAYLOAD || nxt.pay_rem != 32'd0)) begin
      nxt.err = ERR_LENGTH;
    end

    result_o.file_done      = item_i.last_byte;
    result_o.status         = nxt.err;
    result_o.payload_length = nxt.decl_len;
  end

  // Start a fresh file after the last byte
  assign state_o = item_i.last_byte ? StateReset : nxt;

endmodule

`default_nettype wire

[hdl/bitstream_file_header_parser_top.sv]
// ----------------------------------------------------------------------------
// bitstream_file_header_parser_top - bit-file header parser
// Checks the file header, skips info sections and passes the payload on.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one file byte per transfer, with last_byte on the final one.
//   out_o gives one result per input byte: the bit-reversed payload byte
//         with payload_valid, file_done, the held status and the declared
//         payload length.
// Throughput: one byte per cycle while in_i.ready is high. The parser state
//   registers update in the cycle a byte is accepted, so each byte sees the
//   state left by the one before it with no bubble.
// Results: each result is loaded into the output register, or into the
//   second result register while the output is held.
// Stall: a second result register catches one result while the output is
//   held, so the input stays ready for one more byte; in_i.ready drops only
//   while that register is full.
// Reset: all parser state returns to the magic header phase with no error
//   held, and both result registers are empty. The parser also returns to
//   that state by itself after every last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bitstream_file_header_parser_top #(
  parameter int INFO_SECTIONS = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  bfhp_stream_if.sink         in_i,
  bfhp_stream_if.source       out_o
);
  import bfhp_pkg::*;

  parse_state_t state_q, state_d;
  out_item_t    result;
  out_item_t    out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         in_fire;
  logic         out_free;

  bfhp_step #(
    .INFO_SECTIONS(INFO_SECTIONS)
  ) u_step (
    .state_i  (state_q),
    .item_i   (in_i.data),
    .state_o  (state_d),
    .result_o (result)
  );

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Hold parser state, advance on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Track occupancy of the output and skid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Load result payloads
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= result;
      end
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire
